// File: design/assert_macros.svh
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/cprb_pkg.sv
// Types, constants and lookup functions of the control port register bank.
`timescale 1ns / 1ps

package cprb_pkg;

  // Number of bank registers that really exist (64 to 128).
  localparam int REGISTER_COUNT = 128;

  // Writable registers live in flip-flops, one slot each.
  localparam int SLOT_COUNT = 23;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [6:0] ADDR_CTRL     = 7'h00;
  localparam logic [6:0] ADDR_SPEED    = 7'h01;
  localparam logic [6:0] ADDR_FLAG_CLR = 7'h02;
  localparam logic [6:0] ADDR_DEV_KIND = 7'h03;
  localparam logic [6:0] ADDR_MASK3    = 7'h06;
  localparam logic [6:0] ADDR_UNLOCK_A = 7'h07;
  localparam logic [6:0] ADDR_UNLOCK_B = 7'h09;
  localparam logic [6:0] ADDR_UNLOCK_C = 7'h0A;
  localparam logic [6:0] ADDR_LOCK_B   = 7'h0B;
  localparam logic [6:0] ADDR_LOCK_C   = 7'h0C;
  localparam logic [6:0] ADDR_NIBBLE   = 7'h0D;
  localparam logic [6:0] ADDR_MASK2    = 7'h0F;
  localparam logic [6:0] ADDR_BIT3_CLR = 7'h28;

  localparam logic [7:0] SPEED_MASK    = 8'b0001_0011;
  localparam logic [7:0] KEY_HI        = 8'h83;
  localparam logic [7:0] KEY_LO        = 8'h03;
  localparam logic [7:0] SEQ_BITS      = 8'h90;
  localparam logic [7:0] BIT3_CLR_MASK = 8'd247;

  typedef struct packed {
    logic       cmd;
    logic [6:0] port_address;
    logic [7:0] write_data;
  } cprb_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] clock_rate_select;
    logic       clock_rate_changed;
    logic [3:0] unlock_progress;
  } cprb_out_t;

  // One register update, used both for the bank and for the sequencer.
  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [7:0] data;
  } cprb_wr_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } cprb_slot_t;

  // Power-up contents of the bank.
  function automatic logic [7:0] reset_byte(input logic [6:0] addr);
    logic [7:0] v;
    case (addr)
      7'h00: v = 8'h03;
      7'h01: v = 8'h03;
      7'h02: v = 8'h01;
      7'h05: v = 8'h76;
      7'h06: v = 8'h03;
      7'h07: v = 8'hB7;
      7'h08: v = 8'hFD;
      7'h0B: v = 8'h08;
      7'h0D: v = 8'hFF;
      7'h0E: v = 8'h0A;
      7'h0F: v = 8'h42;
      7'h1C: v = 8'h80;
      7'h1F: v = 8'h01;
      7'h22: v = 8'hD0;
      7'h23: v = 8'hFF;
      7'h24: v = 8'hFF;
      7'h25: v = 8'hD3;
      7'h2A: v = 8'h70;
      7'h2B: v = 8'hFE;
      7'h2C: v = 8'hFF;
      7'h30: v = 8'hFF;
      7'h34: v = 8'h30;
      7'h35: v = 8'h03;
      7'h3A: v = 8'hFF;
      7'h3B: v = 8'hFF;
      7'h3C: v = 8'hDF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Bank address held by each flip-flop slot.
  function automatic logic [6:0] slot_address(input logic [SLOT_W-1:0] idx);
    logic [6:0] a;
    case (idx)
      5'd0:  a = 7'h00;
      5'd1:  a = 7'h02;
      5'd2:  a = 7'h04;
      5'd3:  a = 7'h05;
      5'd4:  a = 7'h06;
      5'd5:  a = 7'h07;
      5'd6:  a = 7'h08;
      5'd7:  a = 7'h0A;
      5'd8:  a = 7'h0B;
      5'd9:  a = 7'h0C;
      5'd10: a = 7'h0D;
      5'd11: a = 7'h0E;
      5'd12: a = 7'h0F;
      5'd13: a = 7'h1D;
      5'd14: a = 7'h1E;
      5'd15: a = 7'h1F;
      5'd16: a = 7'h20;
      5'd17: a = 7'h21;
      5'd18: a = 7'h22;
      5'd19: a = 7'h23;
      5'd20: a = 7'h24;
      5'd21: a = 7'h25;
      default: a = 7'h28;
    endcase
    return a;
  endfunction

  // Slot of a writable address; hit is low for read-only addresses.
  function automatic cprb_slot_t slot_of(input logic [6:0] addr);
    cprb_slot_t s;
    s.hit = 1'b1;
    unique case (addr)
      7'h00: s.idx = 5'd0;
      7'h02: s.idx = 5'd1;
      7'h04: s.idx = 5'd2;
      7'h05: s.idx = 5'd3;
      7'h06: s.idx = 5'd4;
      7'h07: s.idx = 5'd5;
      7'h08: s.idx = 5'd6;
      7'h0A: s.idx = 5'd7;
      7'h0B: s.idx = 5'd8;
      7'h0C: s.idx = 5'd9;
      7'h0D: s.idx = 5'd10;
      7'h0E: s.idx = 5'd11;
      7'h0F: s.idx = 5'd12;
      7'h1D: s.idx = 5'd13;
      7'h1E: s.idx = 5'd14;
      7'h1F: s.idx = 5'd15;
      7'h20: s.idx = 5'd16;
      7'h21: s.idx = 5'd17;
      7'h22: s.idx = 5'd18;
      7'h23: s.idx = 5'd19;
      7'h24: s.idx = 5'd20;
      7'h25: s.idx = 5'd21;
      7'h28: s.idx = 5'd22;
      default: begin
        s.hit = 1'b0;
        s.idx = '0;
      end
    endcase
    return s;
  endfunction

  // True when the address falls inside the populated part of the bank.
  function automatic logic in_bank(input logic [6:0] addr);
    return {1'b0, addr} < 8'(REGISTER_COUNT);
  endfunction

endpackage

// File: design/cprb_regfile.sv
// Register bank storage: writable registers in flip-flops, the rest constant.
`timescale 1ns / 1ps

module cprb_regfile (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [6:0]         rd_addr,
  input  cprb_pkg::cprb_wr_t wr,
  output logic [7:0]         rd_data,
  output logic               unlock_c_bit1
);

  logic [7:0] slot_r [cprb_pkg::SLOT_COUNT];

  cprb_pkg::cprb_slot_t rd_slot;
  cprb_pkg::cprb_slot_t wr_slot;
  cprb_pkg::cprb_slot_t c_slot;
  logic [7:0]           raw;

  always_comb begin
    rd_slot = cprb_pkg::slot_of(rd_addr);
    wr_slot = cprb_pkg::slot_of(wr.addr);
    c_slot  = cprb_pkg::slot_of(cprb_pkg::ADDR_UNLOCK_C);
    raw     = rd_slot.hit ? slot_r[rd_slot.idx] : cprb_pkg::reset_byte(rd_addr);
    rd_data = cprb_pkg::in_bank(rd_addr) ? raw : 8'h00;
    unlock_c_bit1 = slot_r[c_slot.idx][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cprb_pkg::SLOT_COUNT; i++) begin
        slot_r[i] <= cprb_pkg::reset_byte(cprb_pkg::slot_address(cprb_pkg::SLOT_W'(i)));
      end
    end else if (wr.en && wr_slot.hit && cprb_pkg::in_bank(wr.addr)) begin
      slot_r[wr_slot.idx] <= wr.data;
    end
  end

endmodule

// File: design/cprb_unlock.sv
// Unlock sequencer: eleven states driven by writes to a few control addresses.
`timescale 1ns / 1ps

module cprb_unlock (
  input  logic               clk,
  input  logic               rst_n,
  input  cprb_pkg::cprb_wr_t step,
  output logic [3:0]         state_nxt
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_1    = 4'd1;
  localparam logic [3:0] ST_2    = 4'd2;
  localparam logic [3:0] ST_3    = 4'd3;
  localparam logic [3:0] ST_4    = 4'd4;
  localparam logic [3:0] ST_5    = 4'd5;
  localparam logic [3:0] ST_6    = 4'd6;
  localparam logic [3:0] ST_7    = 4'd7;
  localparam logic [3:0] ST_8    = 4'd8;
  localparam logic [3:0] ST_9    = 4'd9;
  localparam logic [3:0] ST_OPEN = 4'd10;

  logic [3:0] state_r;
  logic [3:0] after_a;
  logic [7:0] b;

  // Step shared by the two data-pattern addresses.
  function automatic logic [3:0] step_b(input logic [3:0] s, input logic [7:0] d);
    logic [3:0] n;
    unique case (s)
      ST_1:    n = d[7] ? ST_2 : ST_IDLE;
      ST_4:    n = ((d & cprb_pkg::SEQ_BITS) == cprb_pkg::SEQ_BITS) ? ST_5 : ST_IDLE;
      ST_5:    n = !d[4] ? ST_6 : ST_IDLE;
      ST_7:    n = !d[7] ? ST_8 : ST_IDLE;
      default: n = s;
    endcase
    return n;
  endfunction

  always_comb begin
    b = step.data;
    if (state_r == ST_IDLE) begin
      after_a = ((b & cprb_pkg::SEQ_BITS) == cprb_pkg::SEQ_BITS) ? ST_1 : ST_IDLE;
    end else begin
      after_a = ST_IDLE;
    end

    state_nxt = state_r;
    if (step.en) begin
      unique case (step.addr) inside
        cprb_pkg::ADDR_CTRL: begin
          unique case (state_r)
            ST_2:    state_nxt = (b == cprb_pkg::KEY_HI) ? ST_3 : ST_IDLE;
            ST_6:    state_nxt = (b == cprb_pkg::KEY_LO) ? ST_7 : ST_IDLE;
            ST_8:    state_nxt = (b == cprb_pkg::KEY_HI) ? ST_9 : ST_IDLE;
            ST_9:    state_nxt = (b == cprb_pkg::KEY_LO) ? ST_OPEN : ST_IDLE;
            default: state_nxt = state_r;
          endcase
        end
        // This address runs its own check and then the shared step as well.
        cprb_pkg::ADDR_UNLOCK_A: state_nxt = step_b(after_a, b);
        cprb_pkg::ADDR_UNLOCK_B: state_nxt = step_b(state_r, b);
        cprb_pkg::ADDR_UNLOCK_C: begin
          if (state_r == ST_3) begin
            state_nxt = b[0] ? ST_4 : ST_IDLE;
          end
        end
        cprb_pkg::ADDR_LOCK_B,
        cprb_pkg::ADDR_LOCK_C: state_nxt = ST_IDLE;
        default: state_nxt = state_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/control_port_register_bank_unit.sv
// Top level of the control port register bank.
`timescale 1ns / 1ps

// Control port register bank. Each input word is one bus access (read or
// write of one byte at a 7-bit address) and yields exactly one result word
// carrying the read byte, the current clock-rate select, a flag that marks a
// write of the speed register, and the unlock sequencer state after the
// access. The block takes one word per cycle: a word sits in the input
// register while the masked register update, read decode and sequencer
// step run, and its result is captured in the output register once that
// register is free or being emptied. Only a stalled output slows the input.
// All state changes happen as a word moves from the input register to the
// output register, so accesses take effect strictly in order. The device
// type byte returned at address 0x03 is set through the configuration port,
// which is always ready and is meant to be written while no access is in
// flight.

module control_port_register_bank_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cprb_pkg::cprb_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output cprb_pkg::cprb_out_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);

  // Pipeline registers.
  logic                s1_valid_r;
  cprb_pkg::cprb_in_t  s1_word_r;
  logic                out_valid_r;
  cprb_pkg::cprb_out_t out_word_r;
  cprb_pkg::cprb_out_t out_word_nxt;

  // Architectural state kept at the top.
  logic [7:0] device_kind_r;
  logic [4:0] speed_r;
  logic [4:0] speed_nxt;

  logic       s1_adv;
  logic       fire;
  logic       is_wr;
  logic [6:0] addr;
  logic [7:0] b;
  logic [7:0] stored;
  logic [7:0] wr_val;
  logic [7:0] rd_val;
  logic       unlock_c_bit1;
  logic [3:0] unlock_nxt;

  cprb_pkg::cprb_wr_t bank_wr;
  cprb_pkg::cprb_wr_t seq_step;

  // The input register moves on whenever the output register is free or
  // being emptied in this cycle.
  assign s1_adv    = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign fire      = s1_valid_r && s1_adv;
  assign cfg_ready = 1'b1;

  assign is_wr = (s1_word_r.cmd == cprb_pkg::CMD_WRITE);
  assign addr  = s1_word_r.port_address;
  assign b     = s1_word_r.write_data;

  cprb_regfile u_regfile (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd_addr       (addr),
    .wr            (bank_wr),
    .rd_data       (stored),
    .unlock_c_bit1 (unlock_c_bit1)
  );

  cprb_unlock u_unlock (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (seq_step),
    .state_nxt (unlock_nxt)
  );

  // Write masks by address. Addresses without a flip-flop slot drop the
  // write inside the bank, so only the shaped values are listed here.
  always_comb begin
    unique case (addr)
      cprb_pkg::ADDR_FLAG_CLR: wr_val = 8'h00;
      cprb_pkg::ADDR_MASK3:    wr_val = {5'b0, b[2:0]};
      cprb_pkg::ADDR_NIBBLE:   wr_val = {b[3:0], b[3:0]};
      cprb_pkg::ADDR_MASK2:    wr_val = {6'b0, b[1:0]};
      cprb_pkg::ADDR_BIT3_CLR: wr_val = b & cprb_pkg::BIT3_CLR_MASK;
      default:                 wr_val = b;
    endcase
  end

  // Read decode. The status register at 0x0B latches bit 1 whenever it is
  // read while bit 1 of register 0x0A is clear, and the read returns the
  // updated byte.
  always_comb begin
    unique case (addr)
      cprb_pkg::ADDR_SPEED:    rd_val = {3'b0, speed_r};
      cprb_pkg::ADDR_FLAG_CLR: rd_val = stored | 8'h01;
      cprb_pkg::ADDR_DEV_KIND: rd_val = device_kind_r;
      cprb_pkg::ADDR_LOCK_B:   rd_val = unlock_c_bit1 ? stored : (stored | 8'h02);
      default:                 rd_val = stored;
    endcase
  end

  always_comb begin
    bank_wr.addr = addr;
    if (is_wr) begin
      bank_wr.en   = fire && (addr != cprb_pkg::ADDR_SPEED);
      bank_wr.data = wr_val;
    end else begin
      bank_wr.en   = fire && (addr == cprb_pkg::ADDR_LOCK_B) && !unlock_c_bit1;
      bank_wr.data = stored | 8'h02;
    end

    seq_step.en   = fire && is_wr;
    seq_step.addr = addr;
    seq_step.data = b;

    speed_nxt = speed_r;
    if (fire && is_wr && (addr == cprb_pkg::ADDR_SPEED)) begin
      speed_nxt = 5'(b & cprb_pkg::SPEED_MASK);
    end

    out_word_nxt.read_data          = is_wr ? 8'h00 : rd_val;
    out_word_nxt.clock_rate_select  = speed_nxt[1:0];
    out_word_nxt.clock_rate_changed = is_wr && (addr == cprb_pkg::ADDR_SPEED);
    out_word_nxt.unlock_progress    = unlock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      speed_r       <= '0;
      device_kind_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      speed_r <= speed_nxt;
      if (cfg_valid && cfg_ready) begin
        device_kind_r <= cfg_data;
      end
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r <= in_word;
    end
    if (fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: design/cprb_checker.sv
// Port-level checker for the control port register bank, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cprb_port_checks (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input cprb_pkg::cprb_out_t out_word
);

  // A result word that reports a speed write.
  logic chg_valid;
  assign chg_valid = out_valid && out_word.clock_rate_changed;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))
  `ASSERT_SAME(a_changed_no_data, clk, rst_n, chg_valid, out_word.read_data == 8'h00)
  `ASSERT_SAME(a_unlock_range, clk, rst_n, out_valid, out_word.unlock_progress <= 4'd10)

endmodule

bind control_port_register_bank_unit cprb_port_checks u_cprb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// File: test/cprb_checker.sv
// Checker that predicts every result word of the register bank and compares it on arrival.
`timescale 1ns / 1ps

module cprb_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  cprb_pkg::cprb_in_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  cprb_pkg::cprb_out_t out_word,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  awaited
);
  import cprb_pkg::*;

  logic [7:0] bank [0:127];
  logic [4:0] speed;
  logic [3:0] unlock;
  logic [7:0] device_kind;
  cprb_out_t  awaited_results[$];
  int         mismatches = 0;

  // Power-up contents of the bank; every address not listed starts at zero.
  function automatic logic [7:0] power_up_byte(input int a);
    case (a)
      8'h00, 8'h01, 8'h06, 8'h35: return 8'h03;
      8'h02, 8'h1F:               return 8'h01;
      8'h05:                      return 8'h76;
      8'h07:                      return 8'hB7;
      8'h08:                      return 8'hFD;
      8'h0B:                      return 8'h08;
      8'h0E:                      return 8'h0A;
      8'h0F:                      return 8'h42;
      8'h1C:                      return 8'h80;
      8'h22:                      return 8'hD0;
      8'h25:                      return 8'hD3;
      8'h2A:                      return 8'h70;
      8'h2B:                      return 8'hFE;
      8'h34:                      return 8'h30;
      8'h3C:                      return 8'hDF;
      8'h0D, 8'h23, 8'h24, 8'h2C, 8'h30, 8'h3A, 8'h3B: return 8'hFF;
      default:                    return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] bank_read(input logic [6:0] a);
    return (a < REGISTER_COUNT) ? bank[a] : 8'h00;
  endfunction

  function automatic void bank_write(input logic [6:0] a, input logic [7:0] v);
    if (a < REGISTER_COUNT) bank[a] = v;
  endfunction

  // Sequencer step taken by writes to 0x09, and by writes to 0x07 after their own step.
  function automatic void unlock_data_step(input logic [7:0] b);
    case (unlock)
      4'd1: unlock = b[7] ? 4'd2 : 4'd0;
      4'd4: unlock = ((b & SEQ_BITS) == SEQ_BITS) ? 4'd5 : 4'd0;
      4'd5: unlock = !b[4] ? 4'd6 : 4'd0;
      4'd7: unlock = !b[7] ? 4'd8 : 4'd0;
      default: ;
    endcase
  endfunction

  // Applies one bus access to the shadow state and returns the word it should produce.
  function automatic cprb_out_t apply_access(input cprb_in_t acc);
    cprb_out_t  r;
    logic [6:0] a;
    logic [7:0] b;
    logic [7:0] masked;
    logic [7:0] ctl;
    a = acc.port_address;
    b = acc.write_data;
    r = '0;
    if (acc.cmd == CMD_WRITE) begin
      case (a)
        ADDR_CTRL: begin
          bank_write(a, b);
          case (unlock)
            4'd2: unlock = (b == KEY_HI) ? 4'd3 : 4'd0;
            4'd6: unlock = (b == KEY_LO) ? 4'd7 : 4'd0;
            4'd8: unlock = (b == KEY_HI) ? 4'd9 : 4'd0;
            4'd9: unlock = (b == KEY_LO) ? 4'd10 : 4'd0;
            default: ;
          endcase
        end
        ADDR_SPEED: begin
          masked = b & SPEED_MASK;
          speed = masked[4:0];
          r.clock_rate_changed = 1'b1;
        end
        ADDR_FLAG_CLR: bank_write(a, 8'h00);
        ADDR_MASK3:    bank_write(a, {5'b0, b[2:0]});
        ADDR_UNLOCK_A: begin
          if (unlock == 4'd0) begin
            if ((b & SEQ_BITS) == SEQ_BITS) unlock = 4'd1;
          end else begin
            unlock = 4'd0;
          end
          bank_write(a, b);
          unlock_data_step(b);
        end
        ADDR_UNLOCK_B: unlock_data_step(b);
        ADDR_UNLOCK_C: begin
          if (unlock == 4'd3) unlock = b[0] ? 4'd4 : 4'd0;
          bank_write(a, b);
        end
        ADDR_LOCK_B, ADDR_LOCK_C: begin
          unlock = 4'd0;
          bank_write(a, b);
        end
        ADDR_NIBBLE:   bank_write(a, {b[3:0], b[3:0]});
        ADDR_MASK2:    bank_write(a, {6'b0, b[1:0]});
        ADDR_BIT3_CLR: bank_write(a, b & BIT3_CLR_MASK);
        // Plain scratch registers that keep the whole byte.
        7'h04, 7'h05, 7'h08, 7'h0E, 7'h1D, 7'h1E, 7'h1F,
        7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25: bank_write(a, b);
        default: ;
      endcase
    end else begin
      case (a)
        ADDR_SPEED:    r.read_data = {3'b0, speed} & SPEED_MASK;
        ADDR_FLAG_CLR: r.read_data = bank_read(a) | 8'h01;
        ADDR_DEV_KIND: r.read_data = device_kind;
        ADDR_LOCK_B: begin
          ctl = bank_read(ADDR_UNLOCK_C);
          if (!ctl[1]) bank_write(a, bank_read(a) | 8'h02);
          r.read_data = bank_read(a);
        end
        default:       r.read_data = bank_read(a);
      endcase
    end
    r.clock_rate_select = speed[1:0];
    r.unlock_progress   = unlock;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    cprb_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < 128; i++) bank[i] = power_up_byte(i);
      speed       = '0;
      unlock      = '0;
      device_kind = '0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) device_kind = cfg_data;
      if (in_valid && in_ready) awaited_results.push_back(apply_access(in_word));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word %h arrived with none awaited", out_word));
        end else begin
          want = awaited_results.pop_front();
          if (out_word.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      out_word.read_data, want.read_data));
          if (out_word.clock_rate_select !== want.clock_rate_select)
            report_mismatch($sformatf("clock_rate_select %h, expected %h",
                                      out_word.clock_rate_select, want.clock_rate_select));
          if (out_word.clock_rate_changed !== want.clock_rate_changed)
            report_mismatch($sformatf("clock_rate_changed %b, expected %b",
                                      out_word.clock_rate_changed, want.clock_rate_changed));
          if (out_word.unlock_progress !== want.unlock_progress)
            report_mismatch($sformatf("unlock_progress %0d, expected %0d",
                                      out_word.unlock_progress, want.unlock_progress));
        end
      end
    end
    awaited    <= awaited_results.size();
    fail_count <= mismatches;
  end

endmodule

// File: test/testbench.sv
// Top of the register bank testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import cprb_pkg::*;

  // The slowest legal run stays well inside this limit; it leaves a wide margin.
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles allowed after the last awaited word.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_WORDS  = 230;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  cprb_in_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  cprb_out_t out_word;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  int fail_count;
  int awaited;
  int cycle_count = 0;
  int burst_left  = 0;
  int words_sent  = 0;
  int stall_span  = 0;
  int stall_mode  = 0;

  control_port_register_bank_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  cprb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .awaited   (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off here if the block stops producing words.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d result words still awaited", awaited);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // The receiver switches between stall patterns whenever a random span runs out:
  // always ready, mostly ready, mostly stalled, and a strict alternation. The
  // always-ready stretches let the block run at full rate.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(8, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  // Offers one access word and returns at the edge that accepts it. The sender
  // works in bursts; when a burst runs out, valid drops for a random gap (sometimes
  // none) and a new burst length is drawn. Valid is only lowered when a gap
  // follows, so it never falls and rises within one step.
  task automatic issue_access(input logic cmd, input logic [6:0] addr,
                              input logic [7:0] data);
    int       gap;
    cprb_in_t w;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    w.cmd          = cmd;
    w.port_address = addr;
    w.write_data   = data;
    in_word  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Drops valid and waits until every result word has come back. The first edge
  // lets the checker's count catch up with the word accepted last.
  task automatic wait_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // Writes the device type byte through the configuration port.
  task automatic set_device_kind(input logic [7:0] kind);
    cfg_data  <= kind;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One pass through the unlock sequence from state 0 to 10, with random content in
  // every bit that the sequencer does not look at. With break_odds > 0 a step is
  // sometimes replaced by a wrong byte or a lock write, and stray reads are mixed in;
  // reads never move the sequencer.
  task automatic unlock_attempt(input int break_odds);
    logic [6:0] addr;
    logic [7:0] data;
    logic [7:0] noise;
    for (int step = 1; step <= 9; step++) begin
      noise = 8'($urandom);
      case (step)
        1:       begin addr = ADDR_UNLOCK_A; data = noise | SEQ_BITS; end
        2, 8:    begin addr = ADDR_CTRL;     data = KEY_HI;           end
        3:       begin addr = ADDR_UNLOCK_C; data = noise | 8'h01;    end
        4:       begin addr = ADDR_UNLOCK_B; data = noise | SEQ_BITS; end
        // Bit 4 must be clear here, and bit 7 in step seven.
        5:       begin addr = ADDR_UNLOCK_B; data = noise & 8'hEF;    end
        7:       begin addr = ADDR_UNLOCK_B; data = noise & 8'h7F;    end
        default: begin addr = ADDR_CTRL;     data = KEY_LO;           end
      endcase
      if (break_odds > 0 && $urandom_range(1, break_odds) == 1) begin
        if ($urandom_range(0, 1) == 0) data = 8'($urandom);
        else addr = ($urandom_range(0, 1) == 0) ? ADDR_LOCK_B : ADDR_LOCK_C;
      end
      issue_access(CMD_WRITE, addr, data);
      if (break_odds > 0 && $urandom_range(0, 3) == 0)
        issue_access(CMD_READ, 7'($urandom), 8'($urandom));
    end
  endtask

  // Random traffic until the phase has sent its share of words. Most of it is
  // unlock attempts, since only well-formed sequences get past the early states;
  // the rest is single accesses leaning toward the low, decoded addresses.
  task automatic random_traffic(input int quota);
    int         target;
    int         pick;
    logic [6:0] addr;
    logic [7:0] data;
    target = words_sent + quota;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Half the time, clear the sequencer first so the attempt starts from state 0.
        if ($urandom_range(0, 1) == 0) issue_access(CMD_WRITE, ADDR_LOCK_C, 8'($urandom));
        unlock_attempt(($urandom_range(0, 2) == 0) ? 0 : 12);
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    addr = 7'($urandom_range(0, 15));
          2:       addr = 7'($urandom_range(8'h1C, 8'h2F));
          default: addr = 7'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 7))
          0:       data = KEY_HI;
          1:       data = KEY_LO;
          2:       data = 8'($urandom) | SEQ_BITS;
          default: data = 8'($urandom);
        endcase
        issue_access(logic'($urandom_range(0, 1)), addr, data);
      end
    end
  endtask

  initial begin
    logic [7:0] kinds [0:4];
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset values and read side effects, every write mask, an
    // address that ignores writes, and one clean pass through the unlock sequence.
    set_device_kind(8'hFF);
    issue_access(CMD_READ,  ADDR_SPEED,    8'h00);
    issue_access(CMD_READ,  ADDR_FLAG_CLR, 8'hFF);
    issue_access(CMD_READ,  ADDR_DEV_KIND, 8'h00);
    issue_access(CMD_WRITE, ADDR_SPEED,    8'hFF);
    issue_access(CMD_READ,  ADDR_SPEED,    8'h00);
    issue_access(CMD_WRITE, ADDR_FLAG_CLR, 8'hFF);
    issue_access(CMD_READ,  ADDR_FLAG_CLR, 8'h00);
    issue_access(CMD_WRITE, ADDR_NIBBLE,   8'hA5);
    issue_access(CMD_WRITE, ADDR_MASK2,    8'hFF);
    issue_access(CMD_WRITE, ADDR_BIT3_CLR, 8'hFF);
    issue_access(CMD_WRITE, ADDR_MASK3,    8'hFF);
    issue_access(CMD_WRITE, 7'h7F,         8'hFF);
    issue_access(CMD_READ,  7'h7F,         8'hFF);
    // Register 0x0A still has bit 1 clear, so this read sets bit 1 of 0x0B.
    issue_access(CMD_READ,  ADDR_LOCK_B,   8'h00);
    unlock_attempt(0);
    issue_access(CMD_WRITE, ADDR_LOCK_C,   8'h00);
    issue_access(CMD_READ,  ADDR_BIT3_CLR, 8'h00);

    // Random phases, each under its own device type byte.
    kinds[0] = 8'h00;
    kinds[1] = 8'($urandom);
    kinds[2] = 8'hFF;
    kinds[3] = 8'h01;
    kinds[4] = 8'($urandom);
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      set_device_kind(kinds[phase]);
      random_traffic(PHASE_WORDS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
